@@ rtl/b58c_pkg.sv @@
// ----------------------------------------------------------------------------
// b58c_pkg
// Shared types, constants and symbol tables for the permuted base-58 id codec.
// ----------------------------------------------------------------------------
package b58c_pkg;

   // Field widths
   localparam int unsigned ID_IN_W  = 31;
   localparam int unsigned ID_OUT_W = 37;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned OFF_W    = 36;
   localparam int unsigned ACC_W    = 37;
   localparam int unsigned DIG_W    = 6;
   localparam int unsigned NDIGITS  = 6;
   localparam int unsigned RADIX    = 58;
   localparam int unsigned HALF_W   = 18;   // width of a three-digit group

   // Register reset values
   localparam logic [KEY_W-1:0] XOR_KEY_RST = 32'd177451812;
   localparam logic [OFF_W-1:0] OFFSET_RST  = 36'd8728348608;

   // Register indexes on the write port
   localparam logic CSR_XOR_KEY = 1'b0;
   localparam logic CSR_OFFSET  = 1'b1;

   // Operation codes
   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   // Powers of the radix, 58^0 .. 58^6
   localparam logic [ACC_W-1:0] POW58 [0:6] = '{
      37'd1, 37'd58, 37'd3364, 37'd195112, 37'd11316496,
      37'd656356768, 37'd38068692544
   };

   // Symbol alphabet, indexed by digit value
   localparam logic [7:0] ALPHABET [0:57] = '{
      "f","Z","o","d","R","9","X","Q","D","S","U","m","2","1","y","C",
      "k","r","6","z","B","q","i","v","e","Y","a","h","8","b","t","4",
      "x","s","W","p","H","n","J","E","7","j","L","5","V","G","3","g",
      "u","M","T","K","N","P","A","w","c","F"
   };

   // Request payload
   typedef struct packed {
      op_type             operation;
      logic [ID_IN_W-1:0] id_in;
      logic [7:0]         sym_0;
      logic [7:0]         sym_1;
      logic [7:0]         sym_2;
      logic [7:0]         sym_3;
      logic [7:0]         sym_4;
      logic [7:0]         sym_5;
   } req_type;

   // Response payload
   typedef struct packed {
      logic signed [ID_OUT_W-1:0] id_out;
      logic [7:0]                 code_0;
      logic [7:0]                 code_1;
      logic [7:0]                 code_2;
      logic [7:0]                 code_3;
      logic [7:0]                 code_4;
      logic [7:0]                 code_5;
      logic                       bad_symbol;
   } rsp_type;

   // Item as it moves down the pipeline
   typedef struct packed {
      op_type                          op;
      logic                            bad;
      logic [ACC_W-1:0]                acc;
      logic [NDIGITS-1:0][DIG_W-1:0]   dig;
   } pipe_type;

   typedef struct packed {
      logic             hit;
      logic [DIG_W-1:0] digit;
   } sym_lookup_type;

   // Map an ASCII character to its alphabet position
   function automatic sym_lookup_type sym_lookup(input logic [7:0] ch);
      sym_lookup_type res;
      res.hit   = 1'b0;
      res.digit = '0;
      for (int i = 0; i < RADIX; i++) begin
         if (ALPHABET[i] == ch) begin
            res.hit   = 1'b1;
            res.digit = DIG_W'(i);
         end
      end
      return res;
   endfunction

   // Map a digit to its alphabet character; digits past the radix give zero
   function automatic logic [7:0] digit_to_char(input logic [DIG_W-1:0] d);
      logic [7:0] ch;
      ch = '0;
      if (32'(d) < RADIX) begin
         ch = ALPHABET[d];
      end
      return ch;
   endfunction

endpackage

@@ rtl/b58c_front.sv @@
// ----------------------------------------------------------------------------
// b58c_front
// First two pipeline stages: key/offset mixing and modular reduction for
// encode; symbol lookup and three-digit grouping for decode.
// ----------------------------------------------------------------------------
module b58c_front import b58c_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   output logic             in_rdy,
   input  req_type          in_req,
   output logic             out_vld,
   input  logic             out_rdy,
   output pipe_type         out_pipe,
   input  logic [KEY_W-1:0] xor_key,
   input  logic [OFF_W-1:0] offset_value
);

   logic           a_vld_ff;
   pipe_type       a_pipe_ff;
   pipe_type       a_pipe_in;
   logic           a_rdy;
   logic           b_vld_ff;
   pipe_type       b_pipe_ff;
   pipe_type       b_pipe_in;
   logic           b_rdy;
   sym_lookup_type lk [NDIGITS];
   logic [KEY_W-1:0]  mixed;
   logic [HALF_W-1:0] grp_lo;
   logic [HALF_W-1:0] grp_hi;

   // Stage ready: free slot or downstream taking
   assign a_rdy  = !a_vld_ff || b_rdy;
   assign b_rdy  = !b_vld_ff || out_rdy;
   assign in_rdy = a_rdy;

   // Stage A: symbol lookup, or id xor key plus offset
   assign lk[0] = sym_lookup(in_req.sym_0);
   assign lk[1] = sym_lookup(in_req.sym_1);
   assign lk[2] = sym_lookup(in_req.sym_2);
   assign lk[3] = sym_lookup(in_req.sym_3);
   assign lk[4] = sym_lookup(in_req.sym_4);
   assign lk[5] = sym_lookup(in_req.sym_5);
   assign mixed = {1'b0, in_req.id_in} ^ xor_key;

   always_comb begin
      a_pipe_in.op  = in_req.operation;
      a_pipe_in.bad = 1'b0;
      a_pipe_in.acc = '0;
      a_pipe_in.dig = '0;
      if (in_req.operation == OP_ENCODE) begin
         a_pipe_in.acc = ACC_W'(mixed) + ACC_W'(offset_value);
      end else begin
         for (int i = 0; i < NDIGITS; i++) begin
            a_pipe_in.dig[i] = lk[i].digit;
            if (!lk[i].hit) begin
               a_pipe_in.bad = 1'b1;
            end
         end
      end
   end

   // Stage B: reduce mod 58^6, or form two three-digit groups
   assign grp_lo = HALF_W'(a_pipe_ff.dig[0])
                 + HALF_W'(a_pipe_ff.dig[1]) * HALF_W'(POW58[1])
                 + HALF_W'(a_pipe_ff.dig[2]) * HALF_W'(POW58[2]);
   assign grp_hi = HALF_W'(a_pipe_ff.dig[3])
                 + HALF_W'(a_pipe_ff.dig[4]) * HALF_W'(POW58[1])
                 + HALF_W'(a_pipe_ff.dig[5]) * HALF_W'(POW58[2]);

   always_comb begin
      b_pipe_in = a_pipe_ff;
      if (a_pipe_ff.op == OP_ENCODE) begin
         if (a_pipe_ff.acc >= POW58[6]) begin
            b_pipe_in.acc = a_pipe_ff.acc - POW58[6];
         end
      end else begin
         b_pipe_in.acc = {1'b0, grp_hi, grp_lo};
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) begin
            a_vld_ff <= in_vld;
         end
         if (b_rdy) begin
            b_vld_ff <= a_vld_ff;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (a_rdy && in_vld) begin
         a_pipe_ff <= a_pipe_in;
      end
      if (b_rdy && a_vld_ff) begin
         b_pipe_ff <= b_pipe_in;
      end
   end

   assign out_vld  = b_vld_ff;
   assign out_pipe = b_pipe_ff;

endmodule

@@ rtl/b58c_digit.sv @@
// ----------------------------------------------------------------------------
// b58c_digit
// One pipeline stage of base-58 digit extraction: two restoring
// compare-subtract steps against the weight of one digit. Stage zero also
// merges the decode digit groups into the full value.
// ----------------------------------------------------------------------------
module b58c_digit import b58c_pkg::*; #(
   parameter int unsigned STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_vld,
   output logic     in_rdy,
   input  pipe_type in_pipe,
   output logic     out_vld,
   input  logic     out_rdy,
   output pipe_type out_pipe
);

   // Digit 5 down to 1, three stages per digit, two quotient bits per stage
   localparam int unsigned DIGIT  = 5 - STAGE / 3;
   localparam int unsigned BIT_HI = 5 - 2 * (STAGE % 3);
   localparam logic [ACC_W-1:0] STEP_HI = POW58[DIGIT] << BIT_HI;
   localparam logic [ACC_W-1:0] STEP_LO = POW58[DIGIT] << (BIT_HI - 1);

   logic             vld_ff;
   pipe_type         pipe_ff;
   pipe_type         pipe_in;
   logic [ACC_W-1:0] acc_mid;
   logic [OFF_W-1:0] merged;

   assign in_rdy = !vld_ff || out_rdy;

   // Decode: high group times 58^3 plus low group
   assign merged = OFF_W'(in_pipe.acc[2*HALF_W-1:HALF_W]) * OFF_W'(POW58[3])
                 + OFF_W'(in_pipe.acc[HALF_W-1:0]);

   always_comb begin
      pipe_in = in_pipe;
      acc_mid = in_pipe.acc;
      if (in_pipe.op == OP_ENCODE) begin
         if (in_pipe.acc >= STEP_HI) begin
            acc_mid                    = in_pipe.acc - STEP_HI;
            pipe_in.dig[DIGIT][BIT_HI] = 1'b1;
         end
         pipe_in.acc = acc_mid;
         if (acc_mid >= STEP_LO) begin
            pipe_in.acc                  = acc_mid - STEP_LO;
            pipe_in.dig[DIGIT][BIT_HI-1] = 1'b1;
         end
      end else if (STAGE == 0) begin
         pipe_in.acc = {1'b0, merged};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_pipe = pipe_ff;

endmodule

@@ rtl/b58c_out.sv @@
// ----------------------------------------------------------------------------
// b58c_out
// Output stage: maps encode digits to alphabet characters, or applies the
// offset and key to the decoded value, and holds the response register.
// ----------------------------------------------------------------------------
module b58c_out import b58c_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   output logic             in_rdy,
   input  pipe_type         in_pipe,
   output logic             out_vld,
   input  logic             out_rdy,
   output rsp_type          out_rsp,
   input  logic [KEY_W-1:0] xor_key,
   input  logic [OFF_W-1:0] offset_value
);

   logic    vld_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign in_rdy = !vld_ff || out_rdy;

   always_comb begin
      rsp_in = '0;
      if (in_pipe.op == OP_ENCODE) begin
         // remainder left after the digit stages is digit 0
         rsp_in.code_0 = digit_to_char(in_pipe.acc[DIG_W-1:0]);
         rsp_in.code_1 = digit_to_char(in_pipe.dig[1]);
         rsp_in.code_2 = digit_to_char(in_pipe.dig[2]);
         rsp_in.code_3 = digit_to_char(in_pipe.dig[3]);
         rsp_in.code_4 = digit_to_char(in_pipe.dig[4]);
         rsp_in.code_5 = digit_to_char(in_pipe.dig[5]);
      end else begin
         rsp_in.id_out = signed'((in_pipe.acc - ACC_W'(offset_value))
                                 ^ ACC_W'(xor_key));
         rsp_in.bad_symbol = in_pipe.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_rdy) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld = vld_ff;
   assign out_rsp = rsp_ff;

endmodule

@@ rtl/base58_permuted_id_codec_top.sv @@
// Pipeline: two front stages, fifteen digit stages and one output stage lie
// between request transfer and response valid.
// Throughput: one item per cycle; each stage holds its item under backpressure
// and bubbles close up, so the digit extraction chain sets the depth.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// key and offset registers with their default values.
// ----------------------------------------------------------------------------
// base58_permuted_id_codec_top
// Permuted base-58 id codec: encodes an id to six alphabet characters or
// decodes six characters back to an id, one item per cycle when not stalled by the response side.
// ----------------------------------------------------------------------------
module base58_permuted_id_codec_top import b58c_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [OFF_W-1:0] csr_wdata
);

   localparam int unsigned NSTAGES = 15;

   logic [KEY_W-1:0] xor_key_ff;
   logic [OFF_W-1:0] offset_ff;
   logic             stg_vld [0:NSTAGES];
   logic             stg_rdy [0:NSTAGES];
   pipe_type         stg_pipe [0:NSTAGES];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xor_key_ff <= XOR_KEY_RST;
         offset_ff  <= OFFSET_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_XOR_KEY: xor_key_ff <= csr_wdata[KEY_W-1:0];
            CSR_OFFSET:  offset_ff  <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Front stages
   b58c_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (req_valid),
      .in_rdy       (req_ready),
      .in_req       (req_data),
      .out_vld      (stg_vld[0]),
      .out_rdy      (stg_rdy[0]),
      .out_pipe     (stg_pipe[0]),
      .xor_key      (xor_key_ff),
      .offset_value (offset_ff)
   );

   // Digit extraction chain
   for (genvar s = 0; s < NSTAGES; s++) begin : g_digit
      b58c_digit #(.STAGE(s)) u_digit (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (stg_vld[s]),
         .in_rdy   (stg_rdy[s]),
         .in_pipe  (stg_pipe[s]),
         .out_vld  (stg_vld[s+1]),
         .out_rdy  (stg_rdy[s+1]),
         .out_pipe (stg_pipe[s+1])
      );
   end

   // Response register
   b58c_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_vld       (stg_vld[NSTAGES]),
      .in_rdy       (stg_rdy[NSTAGES]),
      .in_pipe      (stg_pipe[NSTAGES]),
      .out_vld      (rsp_valid),
      .out_rdy      (rsp_ready),
      .out_rsp      (rsp_data),
      .xor_key      (xor_key_ff),
      .offset_value (offset_ff)
   );

endmodule

@@ rtl/b58c_checker.sv @@
// ----------------------------------------------------------------------------
// b58c_checker
// Port-level checks for the codec top level, attached by bind.
// ----------------------------------------------------------------------------
module b58c_checker import b58c_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A taking consumer never stalls the producer
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side takes");

   // A decoded id never comes with encode characters
   a_decode_codes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.id_out != 0) || rsp_data.bad_symbol) |->
         (rsp_data.code_0 == 8'd0) && (rsp_data.code_1 == 8'd0) &&
         (rsp_data.code_2 == 8'd0) && (rsp_data.code_3 == 8'd0) &&
         (rsp_data.code_4 == 8'd0) && (rsp_data.code_5 == 8'd0))
      else $error("decode response carries code characters");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind base58_permuted_id_codec_top b58c_checker u_b58c_checker (.*);

@@ verif/base58_permuted_id_codec_top_tb.sv @@
// ----------------------------------------------------------------------------
// base58_permuted_id_codec_top_tb
// Self-checking bench for the permuted base-58 id codec. Requests go in over
// a valid/ready channel, either encode or decode. Each request is converted in
// the bench when its transfer is taken, and every response is compared field
// by field with the oldest pending conversion. The run covers several key and
// offset settings, the extremes among them, and several sender/receiver
// idling mixes.
// ----------------------------------------------------------------------------
module base58_permuted_id_codec_top_tb import b58c_pkg::*; ();

   localparam logic [0:57][7:0] CODE_CHARS =
      "fZodR9XQDSUm21yCkr6zBqiveYah8bt4xsWpHnJE7jL5VG3guMTKNPAwcF";
   localparam logic [OFF_W-1:0] OFFSET_MAX = 36'd38068692543;
   localparam logic [KEY_W-1:0] KEY_MAX    = 32'hFFFF_FFFF;
   localparam int NUM_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int SETTLE_CYCLES  = 40;
   localparam int TIMEOUT_CYCLES = 400000;

   // ------------------------------------------------------------------
   // Conversion checker: mirrors the key/offset registers and keeps the
   // responses owed for requests already transferred.
   // ------------------------------------------------------------------
   class id_codec_checker;
      logic [KEY_W-1:0] key;
      logic [OFF_W-1:0] offset;
      rsp_type          owed_responses[$];
      int               errors;

      function new();
         key    = XOR_KEY_RST;
         offset = OFFSET_RST;
         errors = 0;
      endfunction

      function void set_register(logic index, logic [OFF_W-1:0] value);
         if (index == CSR_XOR_KEY) begin
            key = value[KEY_W-1:0];
         end else begin
            offset = value;
         end
      endfunction

      // Alphabet position of a character, -1 when it is not a code symbol
      function int char_position(logic [7:0] c);
         for (int i = 0; i < 58; i++) begin
            if (CODE_CHARS[i] == c) return i;
         end
         return -1;
      endfunction

      function rsp_type convert(req_type req);
         rsp_type          res;
         logic [ACC_W-1:0] acc;
         logic [7:0]       chars [6];
         logic [5:0][7:0]  syms;
         int               pos;
         res = '0;
         if (req.operation == OP_ENCODE) begin
            // digits above 58^5 fall off the end
            acc = ACC_W'({1'b0, req.id_in} ^ key) + ACC_W'(offset);
            for (int i = 0; i < 6; i++) begin
               chars[i] = CODE_CHARS[acc % 58];
               acc      = acc / 58;
            end
            res.code_0 = chars[0];
            res.code_1 = chars[1];
            res.code_2 = chars[2];
            res.code_3 = chars[3];
            res.code_4 = chars[4];
            res.code_5 = chars[5];
         end else begin
            syms = {req.sym_5, req.sym_4, req.sym_3, req.sym_2, req.sym_1, req.sym_0};
            acc  = '0;
            for (int i = 5; i >= 0; i--) begin
               pos = char_position(syms[i]);
               // unknown symbol flags the result and counts as digit zero
               if (pos < 0) begin
                  res.bad_symbol = 1'b1;
                  pos = 0;
               end
               acc = acc * 58 + ACC_W'(pos);
            end
            res.id_out = (acc - ACC_W'(offset)) ^ ACC_W'(key);
         end
         return res;
      endfunction

      function void log_request(req_type req);
         owed_responses.push_back(convert(req));
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         check_field("id_out", 64'(want.id_out), 64'(got.id_out));
         check_field("code_0", 64'(want.code_0), 64'(got.code_0));
         check_field("code_1", 64'(want.code_1), 64'(got.code_1));
         check_field("code_2", 64'(want.code_2), 64'(got.code_2));
         check_field("code_3", 64'(want.code_3), 64'(got.code_3));
         check_field("code_4", 64'(want.code_4), 64'(got.code_4));
         check_field("code_5", 64'(want.code_5), 64'(got.code_5));
         check_field("bad_symbol", 64'(want.bad_symbol), 64'(got.bad_symbol));
      endfunction

      function int outstanding();
         return owed_responses.size();
      endfunction
   endclass

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_valid    = 1'b0;
   logic             req_ready;
   req_type          req_data     = '0;
   logic             rsp_valid;
   logic             rsp_ready    = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write_en = 1'b0;
   logic             csr_index    = CSR_XOR_KEY;
   logic [OFF_W-1:0] csr_wdata    = '0;

   id_codec_checker  scb = new();
   int               req_idle_pct  = 0;
   int               rsp_stall_pct = 0;

   base58_permuted_id_codec_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Response side: check each transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         scb.check_response(rsp_data);
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Present one request and hold it until its transfer; valid stays high
   task automatic send_request(input req_type req);
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      scb.log_request(req);
   endtask

   // Random sender gap: when taken, valid is dropped until a random draw ends it
   task automatic sender_gap();
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   // Hold off the sender until every owed response has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (scb.outstanding() != 0);
   endtask

   task automatic write_config(input logic [KEY_W-1:0] key, input logic [OFF_W-1:0] offset);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_XOR_KEY;
      csr_wdata    <= OFF_W'(key);
      @(posedge clock);
      scb.set_register(CSR_XOR_KEY, OFF_W'(key));
      csr_index    <= CSR_OFFSET;
      csr_wdata    <= offset;
      @(posedge clock);
      scb.set_register(CSR_OFFSET, offset);
      csr_write_en <= 1'b0;
   endtask

   function automatic req_type make_request(op_type op, logic [ID_IN_W-1:0] id,
                                            logic [5:0][7:0] syms);
      req_type req;
      req.operation = op;
      req.id_in     = id;
      req.sym_0     = syms[0];
      req.sym_1     = syms[1];
      req.sym_2     = syms[2];
      req.sym_3     = syms[3];
      req.sym_4     = syms[4];
      req.sym_5     = syms[5];
      return req;
   endfunction

   // Mostly well-formed codes; some requests carry arbitrary bytes
   function automatic req_type random_request();
      logic [5:0][7:0]     syms;
      logic [ID_IN_W-1:0]  id;
      bit                  clean;
      id = ID_IN_W'($urandom());
      if ($urandom_range(15) == 0) id = $urandom_range(1) ? '1 : '0;
      clean = ($urandom_range(99) < 85);
      for (int i = 0; i < 6; i++) begin
         if (clean || $urandom_range(1)) begin
            syms[i] = CODE_CHARS[$urandom_range(57)];
         end else begin
            syms[i] = 8'($urandom_range(255));
         end
      end
      return make_request($urandom_range(1) ? OP_ENCODE : OP_DECODE, id, syms);
   endfunction

   task automatic directed_requests();
      logic [5:0][7:0] syms;
      // encode extremes and alternating bit patterns
      send_request(make_request(OP_ENCODE, '0, '0));
      send_request(make_request(OP_ENCODE, '1, '1));
      send_request(make_request(OP_ENCODE, 31'd1, {6{8'h55}}));
      send_request(make_request(OP_ENCODE, 31'h5555_5555, {6{8'hAA}}));
      send_request(make_request(OP_ENCODE, 31'h2AAA_AAAA, '0));
      // decode: smallest value gives a negative id, largest value, mixed
      send_request(make_request(OP_DECODE, '1, {6{CODE_CHARS[0]}}));
      send_request(make_request(OP_DECODE, '0, {6{CODE_CHARS[57]}}));
      send_request(make_request(OP_DECODE, 31'h1234_5678, "9RdoZf"));
      // decode with symbols outside the alphabet
      send_request(make_request(OP_DECODE, '0, {6{8'h00}}));
      send_request(make_request(OP_DECODE, '0, {6{8'hFF}}));
      send_request(make_request(OP_DECODE, '0, {6{8'h80}}));
      for (int i = 0; i < 6; i++) begin
         syms    = {6{CODE_CHARS[1]}};
         syms[i] = (i % 2) ? 8'h20 : 8'h7F;
         send_request(make_request(OP_DECODE, '0, syms));
      end
      send_request(make_request(OP_DECODE, '0, {CODE_CHARS[57], 8'h30, CODE_CHARS[0],
                                                 CODE_CHARS[29], 8'hC3, CODE_CHARS[40]}));
   endtask

   // Stimulus
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1: write_config('0, '0);
               2: write_config(KEY_MAX, OFFSET_MAX);
               4: write_config(KEY_MAX, '0);
               5: write_config('0, OFFSET_MAX);
               7: write_config(XOR_KEY_RST, OFFSET_RST);
               default: write_config($urandom(),
                                     OFF_W'({$urandom(), $urandom()} % (64'(OFFSET_MAX) + 1)));
            endcase
         end
         // idling mix rotates through the four modes
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin req_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         if (phase == 0) directed_requests();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sender_gap();
            send_request(random_request());
            if (phase == 3 && n == ITEMS_PER_PHASE / 2) drain();
         end
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scb.errors == 0 && scb.outstanding() == 0) begin
         $display("base58_permuted_id_codec_top regression: pass");
      end else begin
         $display("base58_permuted_id_codec_top regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("base58_permuted_id_codec_top regression: fail");
      $finish;
   end

endmodule
